// File: rtl/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared types and constants for the clamped PID controller.
// ----------------------------------------------------------------------------
package pwc_pkg;

  localparam int ERR_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int INTEG_W   = 32;
  localparam int DERIV_W   = ERR_W + 1;
  localparam int OCAP_W    = 15;
  localparam int ICAP_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int PROD_P_W  = ERR_W + GAIN_W;
  localparam int PROD_I_W  = INTEG_W + GAIN_W;
  localparam int PROD_D_W  = DERIV_W + GAIN_W;
  localparam int SUM_W     = PROD_I_W + 2;
  localparam int FRAC_BITS = 8;
  localparam int SHR_W     = SUM_W - FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_INTEG_GAIN   = 3'd1,
    CFG_DERIV_GAIN   = 3'd2,
    CFG_OUTPUT_CAP   = 3'd3,
    CFG_INTEGRAL_CAP = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } pwc_terms_t;

endpackage

// File: rtl/pwc_state.sv
// ----------------------------------------------------------------------------
// pwc_state
// Holds the integral and the previous error, and forms the clamped integral
// and the derivative for the error sample being taken.
// ----------------------------------------------------------------------------
module pwc_state
  import pwc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic signed [ERR_W-1:0]  error_sample,
  input  logic [ICAP_W-1:0]        integral_cap,
  output pwc_terms_t               terms
);

  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [INTEG_W-1:0] integral_sum_next;
  logic signed [ERR_W-1:0]   previous_error;

  logic signed [INTEG_W:0]   cap_pos;
  logic signed [INTEG_W:0]   cap_neg;
  logic signed [INTEG_W:0]   sum_ext;
  logic signed [INTEG_W:0]   integ_c;
  logic signed [INTEG_W:0]   next_wide;

  always_comb begin
    cap_pos = {2'b00, integral_cap};
    cap_neg = -cap_pos;
    sum_ext = {integral_sum[INTEG_W-1], integral_sum};
    if (sum_ext > cap_pos) begin
      integ_c = cap_pos;
    end else if (sum_ext < cap_neg) begin
      integ_c = cap_neg;
    end else begin
      integ_c = sum_ext;
    end
    next_wide = integ_c + {{(INTEG_W + 1 - ERR_W){error_sample[ERR_W-1]}}, error_sample};
    if (next_wide[INTEG_W] != next_wide[INTEG_W-1]) begin
      integral_sum_next = next_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                             : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integral_sum_next = next_wide[INTEG_W-1:0];
    end
    terms.err   = error_sample;
    terms.integ = integ_c[INTEG_W-1:0];
    terms.deriv = {error_sample[ERR_W-1], error_sample}
                - {previous_error[ERR_W-1], previous_error};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else if (take) begin
      integral_sum   <= integral_sum_next;
      previous_error <= error_sample;
    end
  end

endmodule

// File: rtl/pid_with_clamps.sv
// ----------------------------------------------------------------------------
// pid_with_clamps
// PID controller with a clamp on the stored integral and on the output.
// ----------------------------------------------------------------------------
// One error sample per beat in, one drive value per beat out. The block takes
// a new sample every cycle while in_stall is low; a drive value passes the input
// register, product register and result register after its sample is taken, and
// stalls on the output back up through those three registers before the
// input is stalled. The integral and previous error are updated in the cycle
// the sample is taken, so their update loop sets the rate. Gains
// are signed Q8.8; the weighted sum is shifted right by 8 rounding toward
// minus infinity and clamped to plus or minus output_cap. Write the
// configuration registers only while no sample is in flight.
module pid_with_clamps
  import pwc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ERR_W-1:0]      error_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ERR_W-1:0]      drive_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DAT_W-1:0]         cfg_data
);

  logic signed [GAIN_W-1:0] prop_gain;
  logic signed [GAIN_W-1:0] integ_gain;
  logic signed [GAIN_W-1:0] deriv_gain;
  logic [OCAP_W-1:0]        output_cap;
  logic [ICAP_W-1:0]        integral_cap;

  logic       take;
  logic       out_ready;
  logic       s2_ready;
  logic       s1_ready;
  pwc_terms_t terms_next;

  logic       s1_valid;
  pwc_terms_t s1_terms;

  logic                       s2_valid;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [PROD_P_W-1:0] prod_p_next;
  logic signed [PROD_I_W-1:0] prod_i_next;
  logic signed [PROD_D_W-1:0] prod_d_next;

  logic signed [SUM_W-1:0]    sum_all;
  logic signed [SHR_W-1:0]    sum_shr;
  logic signed [SHR_W-1:0]    ocap_pos;
  logic signed [SHR_W-1:0]    ocap_neg;
  logic signed [SHR_W-1:0]    clamped;
  logic signed [ERR_W-1:0]    drive_out_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      output_cap   <= '0;
      integral_cap <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:    prop_gain    <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:   integ_gain   <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN:   deriv_gain   <= cfg_data[GAIN_W-1:0];
        CFG_OUTPUT_CAP:   output_cap   <= cfg_data[OCAP_W-1:0];
        CFG_INTEGRAL_CAP: integral_cap <= cfg_data[ICAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;
  assign take      = in_valid && s1_ready;

  pwc_state u_state (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .error_sample (error_sample),
    .integral_cap (integral_cap),
    .terms        (terms_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_terms <= terms_next;
    end
  end

  always_comb begin
    prod_p_next = $signed(s1_terms.err) * $signed(prop_gain);
    prod_i_next = $signed(s1_terms.integ) * $signed(integ_gain);
    prod_d_next = $signed(s1_terms.deriv) * $signed(deriv_gain);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
    end
  end

  always_comb begin
    sum_all  = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    sum_shr  = sum_all[SUM_W-1:FRAC_BITS];
    ocap_pos = {{(SHR_W - OCAP_W){1'b0}}, output_cap};
    ocap_neg = -ocap_pos;
    if (sum_shr > ocap_pos) begin
      clamped = ocap_pos;
    end else if (sum_shr < ocap_neg) begin
      clamped = ocap_neg;
    end else begin
      clamped = sum_shr;
    end
    drive_out_next = clamped[ERR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      drive_out <= drive_out_next;
    end
  end

endmodule

// File: rtl/pwc_checker.sv
// ----------------------------------------------------------------------------
// pwc_checker
// Port-level checks for the clamped PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pwc_checker
  import pwc_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [ERR_W-1:0] drive_out
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_out))
    else $error("stalled result beat changed");

  // A new result beat after an empty output traces back to a taken input beat.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result beat without matching input beat");

  // The input only stalls when the output is backed up.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

endmodule

bind pid_with_clamps pwc_checker u_pwc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive_out (drive_out)
);
